FILE: src/quad_thrust_mixer_throttle_assert.svh
// Assertion macros for the quad thrust mixer block.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef QUAD_THRUST_MIXER_THROTTLE_ASSERT_SVH
`define QUAD_THRUST_MIXER_THROTTLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/qtm_pkg.sv
// Shared types, constants and helper functions of the quad thrust mixer.
// No dependencies; used by every module of the block.
package qtm_pkg;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int NUM_MOTORS  = 4;
    localparam int MOTOR_IDX_W = 2;

    // Working widths.
    typedef logic signed [65:0] wide_t;   // product and sum width
    typedef logic signed [32:0] mop_t;    // multiplier operand
    typedef logic signed [31:0] q16_t;    // Q16.16 state value
    typedef logic signed [41:0] curve_t;  // saturated curve value
    typedef logic signed [47:0] horner_t; // first Horner term
    typedef logic [10:0]        pwm_t;
    typedef logic [2:0]         reg_idx_t;
    typedef logic [MOTOR_IDX_W-1:0] motor_idx_t;

    // Register indexes on the configuration port.
    localparam reg_idx_t REG_MIX_MODE     = 3'd0;
    localparam reg_idx_t REG_ARM_GAIN     = 3'd1;
    localparam reg_idx_t REG_HOVER_THRUST = 3'd2;
    localparam reg_idx_t REG_QUARTER_MASS = 3'd3;
    localparam reg_idx_t REG_CURVE_SQUARE = 3'd4;
    localparam reg_idx_t REG_CURVE_LINEAR = 3'd5;
    localparam reg_idx_t REG_CURVE_OFFSET = 3'd6;

    typedef enum logic [1:0] {
        MODE_PITCH = 2'd0,
        MODE_ROLL  = 2'd1,
        MODE_QUAD  = 2'd2,
        MODE_HOLD  = 2'd3
    } mix_mode_t;

    typedef struct packed {
        mix_mode_t          mix_mode;
        logic [30:0]        arm_gain;
        logic [30:0]        hover_thrust;
        logic [30:0]        quarter_mass;
        logic signed [31:0] curve_square;
        logic signed [31:0] curve_linear;
        logic signed [31:0] curve_offset;
    } qtm_cfg_t;

    // Hand-off from the curve sequencer to the PWM scaling stages.
    typedef struct packed {
        logic       valid;
        motor_idx_t idx;
    } qtm_post_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FILT_KEEP,
        ST_FILT_TAKE,
        ST_FILT_DONE,
        ST_MIX_ROLL,
        ST_MIX_PITCH,
        ST_MIX_YAW,
        ST_MIX_BASE,
        ST_THRUST,
        ST_CRV_SQ,
        ST_CRV_T,
        ST_CRV_HI,
        ST_CRV_LO,
        ST_CRV_M,
        ST_DRAIN0,
        ST_DRAIN1,
        ST_OUT
    } qtm_state_t;

    // Arithmetic constants.
    localparam mop_t   FILT_KEEP    = 33'sd65208;
    localparam mop_t   FILT_TAKE    = 33'sd328;
    localparam mop_t   YAW_GAIN     = 33'sd930611;
    localparam wide_t  ROUND_HALF   = 66'sd32768;
    localparam wide_t  Q16_MAX      = 66'sd2147483647;
    localparam wide_t  Q16_MIN      = -66'sd2147483648;
    localparam wide_t  CURVE_SAT_W  = 66'sd1099511627776;
    localparam curve_t CURVE_SAT    = 42'sd1099511627776;
    localparam int     THR_MAX      = 850;
    localparam int     THR_MIN      = 100;
    localparam pwm_t   PWM_BASE     = 11'd1000;

    // Saturate a wide value to a signed 32-bit state value.
    function automatic q16_t sat32(input wide_t x);
        q16_t r;
        if (x > Q16_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < Q16_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/qtm_cfg_regs.sv
// Configuration register file on an APB-style port for the quad thrust mixer.
// Depends on qtm_pkg for the register layout and reset values.
module qtm_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qtm_pkg::ADDR_W-1:0]  paddr,
    input  logic [qtm_pkg::DATA_W-1:0]  pwdata,
    output logic [qtm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output qtm_pkg::qtm_cfg_t           cfg
);
    import qtm_pkg::*;

    qtm_cfg_t cfg_reg;
    qtm_cfg_t cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Write decode; addresses beyond the last register are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MIX_MODE:     cfg_next.mix_mode     = mix_mode_t'(pwdata[1:0]);
                REG_ARM_GAIN:     cfg_next.arm_gain     = pwdata[30:0];
                REG_HOVER_THRUST: cfg_next.hover_thrust = pwdata[30:0];
                REG_QUARTER_MASS: cfg_next.quarter_mass = pwdata[30:0];
                REG_CURVE_SQUARE: cfg_next.curve_square = $signed(pwdata);
                REG_CURVE_LINEAR: cfg_next.curve_linear = $signed(pwdata);
                REG_CURVE_OFFSET: cfg_next.curve_offset = $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mix_mode     <= MODE_HOLD;
            cfg_reg.arm_gain     <= '0;
            cfg_reg.hover_thrust <= '0;
            cfg_reg.quarter_mass <= '0;
            cfg_reg.curve_square <= 32'sd7396;
            cfg_reg.curve_linear <= 32'sd979118;
            cfg_reg.curve_offset <= 32'sd215185;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back, zero-extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_MIX_MODE:     prdata = {30'd0, cfg_reg.mix_mode};
            REG_ARM_GAIN:     prdata = {1'b0, cfg_reg.arm_gain};
            REG_HOVER_THRUST: prdata = {1'b0, cfg_reg.hover_thrust};
            REG_QUARTER_MASS: prdata = {1'b0, cfg_reg.quarter_mass};
            REG_CURVE_SQUARE: prdata = cfg_reg.curve_square;
            REG_CURVE_LINEAR: prdata = cfg_reg.curve_linear;
            REG_CURVE_OFFSET: prdata = cfg_reg.curve_offset;
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: src/qtm_pwm_scale.sv
// Two-stage scaling of a saturated curve value to a PWM compare value.
// Depends on qtm_pkg; fed by the curve sequencer of the top level.
module qtm_pwm_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  qtm_pkg::qtm_post_t  post_in,
    input  qtm_pkg::curve_t     m_sat,
    output qtm_pkg::pwm_t       pwm_work [qtm_pkg::NUM_MOTORS]
);
    import qtm_pkg::*;

    logic signed [52:0] m_ext;
    logic signed [52:0] k_reg;
    logic signed [52:0] m8_reg;
    logic signed [52:0] scaled;
    logic signed [52:0] thr;
    logic [9:0]         thr_clamped;
    qtm_post_t          stage_reg;
    pwm_t               pwm_reg [NUM_MOTORS];

    assign m_ext    = {{11{m_sat[41]}}, m_sat};
    assign pwm_work = pwm_reg;

    // Times 1000 is times 1024 less times 16 less times 8; the division by
    // 2^24 may floor, since any negative value clamps to the minimum anyway.
    assign scaled = k_reg - m8_reg;
    assign thr    = scaled >>> 24;

    always_comb begin
        if (thr > 53'sd850) begin
            thr_clamped = 10'(THR_MAX);
        end else if (thr < 53'sd100) begin
            thr_clamped = 10'(THR_MIN);
        end else begin
            thr_clamped = thr[9:0];
        end
    end

    // First stage: two of the three shifted terms.
    always_ff @(posedge aclk) begin
        if (post_in.valid) begin
            k_reg  <= (m_ext <<< 10) - (m_ext <<< 4);
            m8_reg <= m_ext <<< 3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= post_in;
        end
    end

    // Second stage: final term, clamp and offset into the motor's slot.
    always_ff @(posedge aclk) begin
        if (stage_reg.valid) begin
            pwm_reg[stage_reg.idx] <= pwm_t'({1'b0, thr_clamped}) + PWM_BASE;
        end
    end

endmodule

FILE: src/quad_thrust_mixer_throttle.sv
// Sequence: filter, mixing and thrust steps, then four passes of the throttle
// curve and a drain of the scaling stages; hold mode skips mixing and thrusts.
// A new item is accepted only in the idle state, after the last result has
// been loaded into the output register, which can wait on m_ready; all steps
// share in turn the single 33x33 multiplier.
// Reset: synchronous, active low; clears the sequencer, filter, thrusts, hand-off and output valid.
module quad_thrust_mixer_throttle (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [23:0]          s_torque_roll,
    input  logic signed [23:0]          s_torque_pitch,
    input  logic signed [23:0]          s_torque_yaw,
    input  logic signed [23:0]          s_lift_accel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [10:0]                 m_pwm_motor_one,
    output logic [10:0]                 m_pwm_motor_two,
    output logic [10:0]                 m_pwm_motor_three,
    output logic [10:0]                 m_pwm_motor_four,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qtm_pkg::ADDR_W-1:0]  paddr,
    input  logic [qtm_pkg::DATA_W-1:0]  pwdata,
    output logic [qtm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import qtm_pkg::*;

    `include "quad_thrust_mixer_throttle_assert.svh"

    qtm_cfg_t   cfg;
    qtm_state_t state_reg;
    qtm_state_t state_next;
    motor_idx_t idx_reg;
    motor_idx_t idx_next;

    logic signed [23:0] roll_reg;
    logic signed [23:0] pitch_reg;
    logic signed [23:0] yaw_reg;
    logic signed [23:0] accel_reg;

    q16_t    lift_reg;
    q16_t    store_reg [NUM_MOTORS];
    wide_t   prod_reg;
    wide_t   sum_reg;
    wide_t   gr_reg;
    wide_t   gp_reg;
    wide_t   u_reg;
    wide_t   v_reg;
    wide_t   a_reg;
    wide_t   b_reg;
    horner_t t_reg;
    wide_t   m_reg;
    curve_t  msat_reg;
    curve_t  msat_next;
    wide_t   m_full;
    wide_t   motor_sum;
    wide_t   yaw_term;
    wide_t   base_term;

    mop_t      mul_a;
    mop_t      mul_b;
    logic      out_load;
    qtm_post_t post_reg;
    pwm_t      pwm_work [NUM_MOTORS];
    pwm_t      pwm_out_reg [NUM_MOTORS];
    logic      m_valid_reg;
    logic      pwm_in_range;

    qtm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qtm_pwm_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .post_in  (post_reg),
        .m_sat    (msat_reg),
        .pwm_work (pwm_work)
    );

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_pwm_motor_one   = pwm_out_reg[0];
    assign m_pwm_motor_two   = pwm_out_reg[1];
    assign m_pwm_motor_three = pwm_out_reg[2];
    assign m_pwm_motor_four  = pwm_out_reg[3];

    // Sequencer: next state and motor index.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FILT_KEEP;
                end
            end
            ST_FILT_KEEP: state_next = ST_FILT_TAKE;
            ST_FILT_TAKE: state_next = ST_FILT_DONE;
            ST_FILT_DONE: begin
                idx_next   = '0;
                state_next = (cfg.mix_mode == MODE_HOLD) ? ST_CRV_SQ : ST_MIX_ROLL;
            end
            ST_MIX_ROLL:  state_next = ST_MIX_PITCH;
            ST_MIX_PITCH: state_next = ST_MIX_YAW;
            ST_MIX_YAW:   state_next = ST_MIX_BASE;
            ST_MIX_BASE:  state_next = ST_THRUST;
            ST_THRUST: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == motor_idx_t'(NUM_MOTORS - 1)) begin
                    state_next = ST_CRV_SQ;
                end
            end
            ST_CRV_SQ: state_next = ST_CRV_T;
            ST_CRV_T:  state_next = ST_CRV_HI;
            ST_CRV_HI: state_next = ST_CRV_LO;
            ST_CRV_LO: state_next = ST_CRV_M;
            ST_CRV_M: begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == motor_idx_t'(NUM_MOTORS - 1)) ? ST_DRAIN0 : ST_CRV_SQ;
            end
            ST_DRAIN0: state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and the output load strobe.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        out_load = 1'b0;
        case (state_reg)
            ST_FILT_KEEP: begin
                mul_a = mop_t'(lift_reg);
                mul_b = FILT_KEEP;
            end
            ST_FILT_TAKE: begin
                mul_a = mop_t'(accel_reg);
                mul_b = FILT_TAKE;
            end
            ST_FILT_DONE: begin
                mul_a = mop_t'(roll_reg);
                mul_b = mop_t'({2'b00, cfg.arm_gain});
            end
            ST_MIX_ROLL: begin
                mul_a = mop_t'(pitch_reg);
                mul_b = mop_t'({2'b00, cfg.arm_gain});
            end
            ST_MIX_PITCH: begin
                mul_a = mop_t'(yaw_reg);
                mul_b = YAW_GAIN;
            end
            ST_MIX_YAW: begin
                mul_a = mop_t'(lift_reg);
                mul_b = mop_t'({2'b00, cfg.quarter_mass});
            end
            ST_CRV_SQ: begin
                mul_a = mop_t'(store_reg[idx_reg]);
                mul_b = mop_t'($signed(cfg.curve_square));
            end
            ST_CRV_HI: begin
                mul_a = mop_t'($signed(t_reg[47:16]));
                mul_b = mop_t'(store_reg[idx_reg]);
            end
            ST_CRV_LO: begin
                mul_a = mop_t'({17'd0, t_reg[15:0]});
                mul_b = mop_t'(store_reg[idx_reg]);
            end
            ST_OUT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Shared multiplier, registered before any use of the product.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Item registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            roll_reg  <= s_torque_roll;
            pitch_reg <= s_torque_pitch;
            yaw_reg   <= s_torque_yaw;
            accel_reg <= s_lift_accel;
        end
    end

    // Mixing terms; yaw is taken as zero outside four-axis mode, where the base is the hover thrust.
    assign yaw_term  = (cfg.mix_mode == MODE_QUAD) ? prod_reg : '0;
    assign base_term = (cfg.mix_mode == MODE_QUAD) ? prod_reg
                                                  : {19'd0, cfg.hover_thrust, 16'd0};

    // Motor sums: one and two from a_reg with u_reg, three and four from b_reg
    // with v_reg.
    always_comb begin
        case (idx_reg)
            2'd0:    motor_sum = a_reg + u_reg;
            2'd1:    motor_sum = a_reg - u_reg;
            2'd2:    motor_sum = b_reg + v_reg;
            default: motor_sum = b_reg - v_reg;
        endcase
    end

    // Second Horner step, then saturation before scaling.
    assign m_full = m_reg + (prod_reg >>> 16);

    always_comb begin
        if (m_full > CURVE_SAT_W) begin
            msat_next = CURVE_SAT;
        end else if (m_full < -CURVE_SAT_W) begin
            msat_next = -CURVE_SAT;
        end else begin
            msat_next = m_full[41:0];
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_FILT_TAKE: sum_reg <= prod_reg + ROUND_HALF;
            ST_MIX_ROLL: begin
                gr_reg <= (cfg.mix_mode == MODE_ROLL || cfg.mix_mode == MODE_QUAD)
                          ? prod_reg : '0;
            end
            ST_MIX_PITCH: begin
                gp_reg <= (cfg.mix_mode == MODE_PITCH || cfg.mix_mode == MODE_QUAD)
                          ? prod_reg : '0;
            end
            ST_MIX_YAW: begin
                u_reg <= gp_reg + yaw_term;
                v_reg <= gp_reg - yaw_term;
            end
            ST_MIX_BASE: begin
                a_reg <= base_term - gr_reg + ROUND_HALF;
                b_reg <= base_term + gr_reg + ROUND_HALF;
            end
            ST_CRV_T:  t_reg    <= 48'((prod_reg >>> 16) + wide_t'($signed(cfg.curve_linear)));
            ST_CRV_LO: m_reg    <= prod_reg + wide_t'($signed(cfg.curve_offset));
            ST_CRV_M:  msat_reg <= msat_next;
            default: ;
        endcase
    end

    // Filter state and stored thrusts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lift_reg <= '0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_FILT_DONE) begin
                lift_reg <= sat32((sum_reg + prod_reg) >>> 16);
            end
            if (state_reg == ST_THRUST) begin
                store_reg[idx_reg] <= sat32(motor_sum >>> 16);
            end
        end
    end

    // Hand a saturated curve value to the scaling stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_reg <= '0;
        end else begin
            post_reg.valid <= (state_reg == ST_CRV_M);
            post_reg.idx   <= idx_reg;
        end
    end

    // Output register; the next item may start while this one waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pwm_out_reg <= pwm_work;
        end
    end

    assign pwm_in_range = (pwm_out_reg[0] >= 11'd1100) && (pwm_out_reg[0] <= 11'd1850)
                       && (pwm_out_reg[1] >= 11'd1100) && (pwm_out_reg[1] <= 11'd1850)
                       && (pwm_out_reg[2] >= 11'd1100) && (pwm_out_reg[2] <= 11'd1850)
                       && (pwm_out_reg[3] >= 11'd1100) && (pwm_out_reg[3] <= 11'd1850);

    `QTM_ASSERT_NEXT(a_accept_starts_filter, s_valid && s_ready, state_reg == ST_FILT_KEEP, "accepted item did not start the filter")
    `QTM_ASSERT_NOW(a_pwm_in_range, m_valid, pwm_in_range, "PWM compare value outside 1100..1850")
    `QTM_ASSERT_NOW(a_hold_keeps_thrusts, state_reg == ST_THRUST, cfg.mix_mode != MODE_HOLD, "thrusts written in hold mode")
    `QTM_ASSERT_NOW(a_curve_after_drain, state_reg == ST_OUT, !post_reg.valid, "result loaded before scaling finished")

endmodule
